// ----- rtl/core/selectable_prng_with_range_macros.svh -----
// Assertion helpers used by spr_ctrl.
`ifndef SELECTABLE_PRNG_WITH_RANGE_MACROS_SVH
`define SELECTABLE_PRNG_WITH_RANGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define SPR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/spr_pkg.sv -----
package spr_pkg;

   localparam int WORD_W = 64;
   localparam int LAG_W  = 32;
   localparam int MOD_CNT_W = $clog2(WORD_W);

   localparam logic [63:0] GOLDEN_WORD  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
   localparam logic [63:0] DUO_X_MASK   = 64'hA5A5A5A5A5A5A5A5;
   localparam logic [63:0] DUO_SEED_MUL = 64'h5851F42D4C957F2D;
   localparam logic [63:0] DUO_MUL      = 64'hD3833E804F4C574B;
   localparam logic [14:0] CMWC_MUL     = 15'd18782;
   localparam logic [31:0] CMWC_BASE    = 32'hFFFFFFFE;
   localparam logic [31:0] CARRY_RESET  = 32'd362436;

   typedef enum logic [1:0] {
      ALG_XORO  = 2'd0,
      ALG_CMWC  = 2'd1,
      ALG_SPLIT = 2'd2,
      ALG_DUO   = 2'd3
   } alg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_SEED_XORO,
      OP_SEED_SPLIT,
      OP_DSEED,
      OP_DSEED_Y,
      OP_SWEEP_INIT,
      OP_CSEED,
      OP_XORO,
      OP_CMWC_RD,
      OP_CMWC_MUL,
      OP_CMWC_WR,
      OP_SPLIT_ADD,
      OP_SPLIT_MIX,
      OP_SPLIT_OUT,
      OP_DUO_DRAW,
      OP_DUO_X,
      OP_MOD_GO,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      RS_ZERO,
      RS_ERR,
      RS_LOW,
      RS_RAW,
      RS_MOD
   } rsel_type;

   typedef struct packed {
      op_type   op;
      rsel_type rsel;
   } cmd_type;

   typedef struct packed {
      logic is_seed;
      logic lo_gt_hi;
      logic lo_eq_hi;
      logic full_span;
      logic sweep_last;
      logic mul_done;
      logic mod_done;
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [63:0] seed_value;
      logic [63:0] range_low;
      logic [63:0] range_high;
   } req_word_type;

   typedef struct packed {
      logic [63:0] value;
      logic        range_error;
   } rsp_word_type;

endpackage

// ----- rtl/core/spr_mul.sv -----
module spr_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] product,
   output logic        done
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] part_ff, part_in;
   logic [1:0]  ph_ff, ph_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x, mul_y;

   // Low 64 bits only: lo*lo, then lo*hi and hi*lo shifted up by 32.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      ph_in   = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      case (ph_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         2'd1: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         default: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
      endcase
      part_in = mul_x * mul_y;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         ph_in   = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ph_ff == 2'd1) begin
            acc_in = acc_ff + part_ff;
         end else if (ph_ff != 2'd0) begin
            acc_in = acc_ff + {part_ff[31:0], 32'd0};
         end
         ph_in = ph_ff + 2'd1;
         if (ph_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      part_ff <= part_in;
      if (reset) begin
         ph_ff   <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

// ----- rtl/core/spr_modu.sv -----
module spr_modu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic [63:0] remainder,
   output logic        done
);

   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic [63:0] rem_ff, rem_in;
   logic [spr_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   // Restoring remainder, one dividend bit per cycle.
   always_comb begin
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, q_ff[63]};
      diff    = shifted - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend;
         d_in    = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[62:0], 1'b0};
         rem_in = diff[64] ? shifted[63:0] : diff[63:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {spr_pkg::MOD_CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- rtl/core/spr_dpath.sv -----
module spr_dpath #(
   parameter int          LAG_COUNT = 4096,
   parameter logic [31:0] PHI_WORD  = 32'h9E3779B9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spr_pkg::cmd_type      cmd,
   input  spr_pkg::req_word_type req_word,
   output spr_pkg::status_type   status,
   output spr_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(LAG_COUNT);
   localparam logic [46:0] CMWC_MUL_W = 47'(spr_pkg::CMWC_MUL);

   logic [31:0] lag_mem [LAG_COUNT];

   spr_pkg::req_word_type req_ff;
   spr_pkg::rsp_word_type rsp_ff, rsp_in;
   logic [63:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [63:0] weyl_ff, weyl_in;
   logic [63:0] duo_x_ff, duo_x_in, duo_y_ff, duo_y_in;
   logic [31:0] carry_ff, carry_in;
   logic [IDX_W-1:0] idx_ff, idx_in, idx_next;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic [31:0] win0_ff, win1_ff, win2_ff;
   logic [31:0] rd_ff;
   logic [63:0] t_ff;
   logic [63:0] raw_ff, raw_in;

   logic        mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic [31:0] sweep_val;
   logic [31:0] sweep_cnt32;
   logic [46:0] cm_prod;
   logic [31:0] cm_c0, cm_x0, cm_x, cm_c, cm_lag;
   logic        cm_wrap;
   logic [63:0] xo_b, xo_sum, weyl_sum, z_first, z_mix, duo_diff;
   logic        mul_start, mul_done, mod_done;
   logic [63:0] mul_a, mul_b, mul_p, mod_rem, span;

   assign idx_next    = idx_ff + 1'b1;
   assign sweep_cnt32 = 32'(sweep_ff);
   assign span        = req_ff.range_high - req_ff.range_low + 64'd1;

   always_comb begin
      if (sweep_ff == '0) begin
         sweep_val = win2_ff;
      end else if (sweep_cnt32 < 32'd3) begin
         sweep_val = win2_ff + PHI_WORD;
      end else begin
         sweep_val = win0_ff ^ win1_ff ^ PHI_WORD ^ sweep_cnt32;
      end
   end

   assign cm_prod = rd_ff * CMWC_MUL_W;
   assign cm_c0   = t_ff[63:32];
   assign cm_x0   = t_ff[31:0] + cm_c0;
   assign cm_wrap = cm_x0 < cm_c0;
   assign cm_x    = cm_x0 + 32'(cm_wrap);
   assign cm_c    = cm_c0 + 32'(cm_wrap);
   assign cm_lag  = spr_pkg::CMWC_BASE - cm_x;

   assign xo_sum   = x0_ff + x1_ff;
   assign xo_b     = x1_ff ^ x0_ff;
   assign weyl_sum = weyl_ff + spr_pkg::GOLDEN_WORD;
   assign z_first  = weyl_sum ^ (weyl_sum >> 30);
   assign z_mix    = mul_p ^ (mul_p >> 27);
   assign duo_diff = duo_y_ff - duo_x_ff;

   // Pick the memory write and the multiplier job for this command.
   always_comb begin
      mem_we    = 1'b0;
      mem_wa    = sweep_ff;
      mem_wd    = '0;
      mul_start = 1'b0;
      mul_a     = duo_y_ff;
      mul_b     = spr_pkg::DUO_MUL;
      case (cmd.op)
         spr_pkg::OP_CLEAR: begin
            mem_we = 1'b1;
         end
         spr_pkg::OP_CSEED: begin
            mem_we = 1'b1;
            mem_wd = sweep_val;
         end
         spr_pkg::OP_CMWC_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = cm_lag;
         end
         spr_pkg::OP_SPLIT_ADD: begin
            mul_start = 1'b1;
            mul_a     = z_first;
            mul_b     = spr_pkg::MIX_MUL_A;
         end
         spr_pkg::OP_SPLIT_MIX: begin
            mul_start = 1'b1;
            mul_a     = z_mix;
            mul_b     = spr_pkg::MIX_MUL_B;
         end
         spr_pkg::OP_DUO_DRAW: begin
            mul_start = 1'b1;
         end
         spr_pkg::OP_DSEED: begin
            mul_start = 1'b1;
            mul_a     = req_ff.seed_value;
            mul_b     = spr_pkg::DUO_SEED_MUL;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      weyl_in  = weyl_ff;
      duo_x_in = duo_x_ff;
      duo_y_in = duo_y_ff;
      carry_in = carry_ff;
      idx_in   = idx_ff;
      sweep_in = sweep_ff;
      raw_in   = raw_ff;
      rsp_in   = rsp_ff;
      case (cmd.op)
         spr_pkg::OP_CLEAR, spr_pkg::OP_CSEED: begin
            sweep_in = sweep_ff + 1'b1;
         end
         spr_pkg::OP_SWEEP_INIT: begin
            sweep_in = '0;
         end
         spr_pkg::OP_SEED_XORO: begin
            x0_in = req_ff.seed_value;
            x1_in = req_ff.seed_value ^ spr_pkg::GOLDEN_WORD;
            if (req_ff.seed_value == '0 && x1_in == '0) begin
               x1_in = 64'd1;
            end
         end
         spr_pkg::OP_SEED_SPLIT: begin
            weyl_in = req_ff.seed_value;
         end
         spr_pkg::OP_DSEED: begin
            duo_x_in = req_ff.seed_value ^ spr_pkg::DUO_X_MASK;
         end
         spr_pkg::OP_DSEED_Y: begin
            duo_y_in = mul_p + 64'd1;
         end
         spr_pkg::OP_XORO: begin
            raw_in = xo_sum;
            x0_in  = {x0_ff[8:0], x0_ff[63:9]} ^ xo_b ^ (xo_b << 14);
            x1_in  = {xo_b[27:0], xo_b[63:28]};
         end
         spr_pkg::OP_CMWC_RD: begin
            idx_in = idx_next;
         end
         spr_pkg::OP_CMWC_WR: begin
            carry_in = cm_c;
            raw_in   = {32'd0, cm_lag};
         end
         spr_pkg::OP_SPLIT_ADD: begin
            weyl_in = weyl_sum;
         end
         spr_pkg::OP_SPLIT_OUT: begin
            raw_in = mul_p ^ (mul_p >> 31);
         end
         spr_pkg::OP_DUO_DRAW: begin
            raw_in   = duo_x_ff;
            duo_y_in = {duo_diff[36:0], duo_diff[63:37]};
         end
         spr_pkg::OP_DUO_X: begin
            duo_x_in = mul_p;
         end
         spr_pkg::OP_EMIT: begin
            case (cmd.rsel)
               spr_pkg::RS_ERR: rsp_in = '{value: '0, range_error: 1'b1};
               spr_pkg::RS_LOW: rsp_in = '{value: req_ff.range_low, range_error: 1'b0};
               spr_pkg::RS_RAW: rsp_in = '{value: raw_ff, range_error: 1'b0};
               spr_pkg::RS_MOD: begin
                  rsp_in = '{value: req_ff.range_low + mod_rem, range_error: 1'b0};
               end
               default: rsp_in = '{value: '0, range_error: 1'b0};
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lag_mem[mem_wa] <= mem_wd;
      end
      if (cmd.op == spr_pkg::OP_CMWC_RD) begin
         rd_ff <= lag_mem[idx_next];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == spr_pkg::OP_LOAD) begin
         req_ff <= req_word;
      end
      if (cmd.op == spr_pkg::OP_SWEEP_INIT) begin
         win2_ff <= req_ff.seed_value[31:0];
      end else if (cmd.op == spr_pkg::OP_CSEED) begin
         win0_ff <= win1_ff;
         win1_ff <= win2_ff;
         win2_ff <= sweep_val;
      end
      t_ff   <= {17'd0, cm_prod} + {32'd0, carry_ff};
      raw_ff <= raw_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         x0_ff    <= 64'd1;
         x1_ff    <= 64'd2;
         weyl_ff  <= '0;
         duo_x_ff <= '0;
         duo_y_ff <= '0;
         carry_ff <= spr_pkg::CARRY_RESET;
         idx_ff   <= '1;
         sweep_ff <= '0;
      end else begin
         x0_ff    <= x0_in;
         x1_ff    <= x1_in;
         weyl_ff  <= weyl_in;
         duo_x_ff <= duo_x_in;
         duo_y_ff <= duo_y_in;
         carry_ff <= carry_in;
         idx_ff   <= idx_in;
         sweep_ff <= sweep_in;
      end
   end

   spr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .done    (mul_done)
   );

   spr_modu u_modu (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.op == spr_pkg::OP_MOD_GO),
      .dividend  (raw_ff),
      .divisor   (span),
      .remainder (mod_rem),
      .done      (mod_done)
   );

   assign status.is_seed    = req_ff.req_type;
   assign status.lo_gt_hi   = req_ff.range_low > req_ff.range_high;
   assign status.lo_eq_hi   = req_ff.range_low == req_ff.range_high;
   assign status.full_span  = (req_ff.range_low == '0) && (req_ff.range_high == '1);
   assign status.sweep_last = sweep_ff == IDX_W'(LAG_COUNT - 1);
   assign status.mul_done   = mul_done;
   assign status.mod_done   = mod_done;

   assign rsp_word = rsp_ff;

endmodule

// ----- rtl/core/spr_ctrl.sv -----
`include "selectable_prng_with_range_macros.svh"

module spr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data,
   input  spr_pkg::status_type status,
   output spr_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_CSEED,
      ST_DSEED_W,
      ST_CMWC_MUL,
      ST_CMWC_WR,
      ST_SPLIT_W1,
      ST_SPLIT_W2,
      ST_DUO_W,
      ST_RAW,
      ST_MOD_W,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   spr_pkg::alg_type   alg_ff, alg_in;
   spr_pkg::rsel_type  rsel_ff, rsel_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      rsel_in  = rsel_ff;
      cmd.op   = spr_pkg::OP_NONE;
      cmd.rsel = rsel_ff;
      alg_in   = csr_wr_en ? spr_pkg::alg_type'(csr_wr_data) : alg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = spr_pkg::OP_CLEAR;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = spr_pkg::OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rsel_in = spr_pkg::RS_ZERO;
            if (status.is_seed) begin
               case (alg_ff)
                  spr_pkg::ALG_CMWC: begin
                     cmd.op   = spr_pkg::OP_SWEEP_INIT;
                     state_in = ST_CSEED;
                  end
                  spr_pkg::ALG_SPLIT: begin
                     cmd.op   = spr_pkg::OP_SEED_SPLIT;
                     state_in = ST_EMIT;
                  end
                  spr_pkg::ALG_DUO: begin
                     cmd.op   = spr_pkg::OP_DSEED;
                     state_in = ST_DSEED_W;
                  end
                  default: begin
                     cmd.op   = spr_pkg::OP_SEED_XORO;
                     state_in = ST_EMIT;
                  end
               endcase
            end else if (status.lo_gt_hi) begin
               rsel_in  = spr_pkg::RS_ERR;
               state_in = ST_EMIT;
            end else if (status.lo_eq_hi) begin
               rsel_in  = spr_pkg::RS_LOW;
               state_in = ST_EMIT;
            end else begin
               case (alg_ff)
                  spr_pkg::ALG_CMWC: begin
                     cmd.op   = spr_pkg::OP_CMWC_RD;
                     state_in = ST_CMWC_MUL;
                  end
                  spr_pkg::ALG_SPLIT: begin
                     cmd.op   = spr_pkg::OP_SPLIT_ADD;
                     state_in = ST_SPLIT_W1;
                  end
                  spr_pkg::ALG_DUO: begin
                     cmd.op   = spr_pkg::OP_DUO_DRAW;
                     state_in = ST_DUO_W;
                  end
                  default: begin
                     cmd.op   = spr_pkg::OP_XORO;
                     state_in = ST_RAW;
                  end
               endcase
            end
         end
         ST_CSEED: begin
            cmd.op = spr_pkg::OP_CSEED;
            if (status.sweep_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_DSEED_W: begin
            if (status.mul_done) begin
               cmd.op   = spr_pkg::OP_DSEED_Y;
               state_in = ST_EMIT;
            end
         end
         ST_CMWC_MUL: begin
            cmd.op   = spr_pkg::OP_CMWC_MUL;
            state_in = ST_CMWC_WR;
         end
         ST_CMWC_WR: begin
            cmd.op   = spr_pkg::OP_CMWC_WR;
            state_in = ST_RAW;
         end
         ST_SPLIT_W1: begin
            if (status.mul_done) begin
               cmd.op   = spr_pkg::OP_SPLIT_MIX;
               state_in = ST_SPLIT_W2;
            end
         end
         ST_SPLIT_W2: begin
            if (status.mul_done) begin
               cmd.op   = spr_pkg::OP_SPLIT_OUT;
               state_in = ST_RAW;
            end
         end
         ST_DUO_W: begin
            if (status.mul_done) begin
               cmd.op   = spr_pkg::OP_DUO_X;
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            if (status.full_span) begin
               rsel_in  = spr_pkg::RS_RAW;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = spr_pkg::OP_MOD_GO;
               state_in = ST_MOD_W;
            end
         end
         ST_MOD_W: begin
            if (status.mod_done) begin
               rsel_in  = spr_pkg::RS_MOD;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.op       = spr_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         alg_ff       <= spr_pkg::ALG_XORO;
         rsel_ff      <= spr_pkg::RS_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alg_ff       <= alg_in;
         rsel_ff      <= rsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `SPR_ASSERT_NXT(a_load_decides, clock, reset, req_valid && req_ready, state_ff == ST_DECIDE)
   `SPR_ASSERT_IMP(a_emit_no_overwrite, clock, reset, cmd.op == spr_pkg::OP_EMIT, out_free)
   `SPR_ASSERT_IMP(a_mul_done_waited, clock, reset, status.mul_done,
      state_ff == ST_DSEED_W || state_ff == ST_SPLIT_W1 || state_ff == ST_SPLIT_W2 ||
      state_ff == ST_DUO_W)
   `SPR_ASSERT_IMP(a_mod_done_waited, clock, reset, status.mod_done, state_ff == ST_MOD_W)

endmodule

// ----- rtl/core/selectable_prng_with_range.sv -----
// Random-number generator with four selectable algorithms (csr algorithm: 0
// xoroshiro128+, 1 CMWC4096, 2 splitmix64, 3 RomuDuoJr), each keeping its own
// state. A request word either seeds the selected generator (response value
// 0) or draws range_low + raw mod (range_high - range_low + 1); an empty
// range answers 0 with range_error set and a single-value range answers
// range_low, neither advancing any generator, and the full 64-bit span
// returns the raw draw. One word is in flight at a time: a draw that is not
// full-span runs through the bit-serial 64-step remainder unit, and splitmix64
// draws also make two passes through the 64-bit multiplier; seeding CMWC
// writes all LAG_COUNT lags one per cycle.
// After reset the lag memory is cleared while req_ready stays low; csr writes
// are taken at any time but should only be made while the block is idle. A
// finished response waits in an output register, so the next request word is
// accepted while it is still unread.
module selectable_prng_with_range #(
   parameter int          LAG_COUNT = 4096,
   parameter logic [31:0] PHI_WORD  = 32'h9E3779B9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spr_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_wr_data
);

   // Command from the sequencer and status back from the datapath.
   spr_pkg::cmd_type    cmd;
   spr_pkg::status_type status;

   // Sequencer: holds the algorithm select and the response handshake.
   spr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: generator states, lag memory, multiplier and remainder unit.
   spr_dpath #(
      .LAG_COUNT (LAG_COUNT),
      .PHI_WORD  (PHI_WORD)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule
